FILE: hdl/rrts_pkg.sv
// Package for the round-robin thread scheduler.
// Holds the op codes, result codes, slot status codes and controller/datapath structs.
// Has no dependencies.
package rrts_pkg;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_SCHEDULE = 3'd1;
    localparam logic [2:0] OP_SLEEP    = 3'd2;
    localparam logic [2:0] OP_DESTROY  = 3'd3;
    localparam logic [2:0] OP_RELEASE  = 3'd4;

    localparam logic [2:0] CODE_OK        = 3'd0;
    localparam logic [2:0] CODE_FULL      = 3'd1;
    localparam logic [2:0] CODE_INVALID   = 3'd2;
    localparam logic [2:0] CODE_NOT_DONE  = 3'd3;
    localparam logic [2:0] CODE_NONE_RDY  = 3'd4;

    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;
    localparam logic [2:0] ST_RETIRED  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the operation inputs
        logic exec;     // perform the single-cycle part of the operation
        logic step;     // perform one ring walk step (schedule or unlink search)
        logic finish;   // drive the result beat
    } rrts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk;     // the operation needs a ring walk
        logic walk_end; // the current step ends the walk
    } rrts_sts_t;

endpackage

FILE: hdl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler: top level joining controller and datapath.
// Create, destroy and release go from start through execute to the done beat; schedule and
// sleep add a walk of ring steps in between, one link followed per cycle.
// Release of a done slot in the ring also walks, following links to its predecessor.
// busy holds off start through the done beat; an operation is never stalled.
// Asynchronous active-low reset: slot 0 running and alone in the ring, others free.
module round_robin_thread_scheduler #(
    parameter int THREAD_SLOTS = 8,
    parameter int TIME_WIDTH   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [2:0]  slot,
    input  logic [31:0] now,
    input  logic [23:0] duration,
    output logic        done,
    output logic [2:0]  code,
    output logic [2:0]  new_slot,
    output logic [2:0]  running
);
    import rrts_pkg::*;

    rrts_cmd_t cmd;
    rrts_sts_t sts;

    // The controller sequences load, execute, ring walk and the result beat.
    rrts_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the slot tables and does one ring step per walk cycle.
    rrts_dp #(
        .SLOTS (THREAD_SLOTS),
        .TW    (TIME_WIDTH)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .op       (op),
        .slot     (slot),
        .now      (now),
        .duration (duration),
        .code     (code),
        .new_slot (new_slot),
        .running  (running)
    );

    // The done beat is a one-cycle strobe marking the result.
    assign done = cmd.finish;

    // A result beat always closes a busy period.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");
    // After a result beat the block is idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy after done");
    // An accepted start makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("start not taken");
endmodule

FILE: hdl/rrts_ctrl.sv
// Controller state machine of the round-robin thread scheduler.
// Depends on rrts_pkg.
module rrts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rrts_pkg::rrts_sts_t sts,
    output rrts_pkg::rrts_cmd_t cmd,
    output logic                busy
);
    import rrts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = sts.walk ? S_WALK : S_DONE;
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (sts.walk_end)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

FILE: hdl/rrts_dp.sv
// Datapath of the round-robin thread scheduler: slot tables, ring pointers, walk step.
// Depends on rrts_pkg.
module rrts_dp #(
    parameter int SLOTS = 8,
    parameter int TW    = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rrts_pkg::rrts_cmd_t cmd,
    output rrts_pkg::rrts_sts_t sts,
    input  logic [2:0]          op,
    input  logic [2:0]          slot,
    input  logic [31:0]         now,
    input  logic [23:0]         duration,
    output logic [2:0]          code,
    output logic [2:0]          new_slot,
    output logic [2:0]          running
);
    import rrts_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [2:0]    stat_reg [SLOTS];
    logic [2:0]    stat_next [SLOTS];
    logic [SW-1:0] link_reg [SLOTS];
    logic [SW-1:0] link_next [SLOTS];
    logic [TW-1:0] wake_reg [SLOTS];
    logic [TW-1:0] wake_next [SLOTS];
    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic [2:0]    op_reg;
    logic [2:0]    slot_reg;
    logic [TW-1:0] now_reg;
    logic [23:0]   dur_reg;
    logic [2:0]    code_reg, code_next;
    logic [2:0]    made_reg, made_next;
    logic          walk_reg, walk_next;
    logic          end_c;
    logic [TW-1:0] wide_now;
    logic [TW-1:0] wake_sum;
    logic          found;
    logic [SW-1:0] free_idx;
    logic          slot_ok;
    logic [SW-1:0] s_idx;
    logic [SW-1:0] h, nx;

    assign wide_now = TW'(now);
    assign wake_sum = now_reg + TW'(dur_reg);
    assign slot_ok  = (slot_reg != 3'd0) && (32'(slot_reg) < SLOTS);
    assign s_idx    = SW'(slot_reg);

    always_comb
    begin
        found = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 1; i--)
        begin
            if (stat_reg[i] == ST_FREE)
            begin
                found = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        stat_next = stat_reg;
        link_next = link_reg;
        wake_next = wake_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        drop_next = drop_reg;
        cnt_next  = cnt_reg;
        prev_next = prev_reg;
        code_next = code_reg;
        made_next = made_reg;
        walk_next = walk_reg;
        end_c = 1'b0;
        h  = head_reg;
        nx = link_reg[head_reg];
        if (cmd.load)
        begin
            code_next = CODE_OK;
            made_next = 3'd0;
            walk_next = 1'b0;
        end
        if (cmd.exec)
        begin
            cnt_next = '0;
            prev_next = head_reg;
            case (op_reg)
                OP_CREATE:
                begin
                    if (!found)
                        code_next = CODE_FULL;
                    else
                    begin
                        stat_next[free_idx] = ST_READY;
                        wake_next[free_idx] = '0;
                        link_next[free_idx] = head_reg;
                        link_next[tail_reg] = free_idx;
                        tail_next = free_idx;
                        made_next = 3'(free_idx);
                    end
                end
                OP_SCHEDULE, OP_SLEEP:
                begin
                    walk_next = 1'b1;
                    drop_next = 1'b0;
                    if (op_reg == OP_SLEEP && stat_reg[head_reg] != ST_DONE)
                    begin
                        wake_next[head_reg] = wake_sum;
                        stat_next[head_reg] = ST_SLEEPING;
                    end
                    else if (stat_reg[head_reg] == ST_DONE)
                        drop_next = 1'b1;
                    else if (stat_reg[head_reg] == ST_RUNNING)
                        stat_next[head_reg] = ST_READY;
                end
                OP_DESTROY, OP_RELEASE:
                begin
                    if (!slot_ok || stat_reg[s_idx] == ST_FREE)
                        code_next = CODE_INVALID;
                    else if (op_reg == OP_DESTROY)
                    begin
                        if (stat_reg[s_idx] != ST_DONE && stat_reg[s_idx] != ST_RETIRED)
                            stat_next[s_idx] = ST_DONE;
                    end
                    else if (stat_reg[s_idx] == ST_RETIRED)
                    begin
                        stat_next[s_idx] = ST_FREE;
                        wake_next[s_idx] = '0;
                        link_next[s_idx] = '0;
                    end
                    else if (stat_reg[s_idx] != ST_DONE || head_reg == s_idx)
                        code_next = CODE_NOT_DONE;
                    else
                        walk_next = 1'b1;
                end
                default: ;
            endcase
        end
        if (cmd.step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (op_reg == OP_RELEASE)
            begin
                // Search one link per cycle for the predecessor of the released slot.
                if (link_reg[prev_reg] == s_idx)
                begin
                    link_next[prev_reg] = link_reg[s_idx];
                    if (tail_reg == s_idx)
                        tail_next = prev_reg;
                    stat_next[s_idx] = ST_FREE;
                    wake_next[s_idx] = '0;
                    link_next[s_idx] = '0;
                    end_c = 1'b1;
                end
                else if (32'(cnt_reg) == SLOTS)
                begin
                    stat_next[s_idx] = ST_FREE;
                    wake_next[s_idx] = '0;
                    link_next[s_idx] = '0;
                    end_c = 1'b1;
                end
                else
                    prev_next = link_reg[prev_reg];
            end
            else
            begin
                // One ring advance: retire or rotate the head, then test the new head.
                if (drop_reg)
                begin
                    stat_next[head_reg] = ST_RETIRED;
                    link_next[tail_reg] = nx;
                end
                else
                    tail_next = head_reg;
                h = nx;
                head_next = h;
                drop_next = 1'b0;
                if (stat_reg[h] == ST_SLEEPING && now_reg >= wake_reg[h])
                begin
                    wake_next[h] = '0;
                    stat_next[h] = ST_RUNNING;
                    end_c = 1'b1;
                end
                else if (stat_reg[h] == ST_DONE)
                    drop_next = 1'b1;
                else if (stat_reg[h] == ST_READY)
                begin
                    stat_next[h] = ST_RUNNING;
                    end_c = 1'b1;
                end
                if (!end_c && 32'(cnt_reg) == SLOTS - 1)
                begin
                    code_next = CODE_NONE_RDY;
                    end_c = 1'b1;
                end
            end
        end
    end

    assign sts.walk     = walk_next;
    assign sts.walk_end = end_c;

    assign code     = cmd.finish ? code_reg : 3'd0;
    assign new_slot = cmd.finish ? made_reg : 3'd0;
    assign running  = cmd.finish ? 3'(head_reg) : 3'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            slot_reg <= slot;
            now_reg  <= wide_now;
            dur_reg  <= duration;
        end
        prev_reg <= prev_next;
        code_reg <= code_next;
        made_reg <= made_next;
        walk_reg <= walk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                stat_reg[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
                link_reg[i] <= '0;
                wake_reg[i] <= '0;
            end
            head_reg <= '0;
            tail_reg <= '0;
            drop_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            stat_reg <= stat_next;
            link_reg <= link_next;
            wake_reg <= wake_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            drop_reg <= drop_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule
